// ===== rtl/core/smns_pkg.sv =====
// Shared types and constants for the signal mask nesting stack.
// Opcodes, status codes, action kinds, register indexes and table/frame records.
// No dependencies.
package smns_pkg;

    localparam int SIG_W     = 5;
    localparam int HANDLER_W = 48;
    localparam int WORD_W    = 32;

    typedef enum logic [1:0] {
        OP_SET_ACTION  = 2'd0,
        OP_DELIVER     = 2'd1,
        OP_PUSH_FRAME  = 2'd2,
        OP_POLL_RETURN = 2'd3
    } opcode_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_IGNORE  = 2'd1;
    localparam logic [1:0] KIND_HANDLER = 2'd2;

    localparam logic [1:0] CFG_NODEFER   = 2'd0;
    localparam logic [1:0] CFG_RESETHAND = 2'd1;
    localparam logic [1:0] CFG_KILL      = 2'd2;
    localparam logic [1:0] CFG_STOP      = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [HANDLER_W-1:0] handler;
        logic [WORD_W-1:0]    mask;
        logic [WORD_W-1:0]    flags;
    } action_entry_t;

    // clear drops the entry back to default without touching the array
    typedef struct packed {
        logic          wr_en;
        logic          clear;
        action_entry_t data;
    } table_wr_t;

    typedef struct packed {
        logic [SIG_W-1:0]  signal;
        logic [WORD_W-1:0] saved_mask;
        logic [WORD_W-1:0] entry_sp;
        logic [WORD_W-1:0] return_pc;
        logic              has_save;
    } frame_t;

endpackage

// ===== rtl/core/smns_action_table.sv =====
// Per-signal action table: synchronous array with a registered read.
// Per-entry valid flops give the reset value (default action) without a sweep.
// Depends on smns_pkg.
module smns_action_table
    import smns_pkg::*;
#(
    parameter int SIGNAL_COUNT = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [$clog2(SIGNAL_COUNT)-1:0]   rd_idx,
    output action_entry_t                     rd_entry,
    input  table_wr_t                         wr,
    input  logic [$clog2(SIGNAL_COUNT)-1:0]   wr_idx
);

    action_entry_t mem [SIGNAL_COUNT];
    action_entry_t rd_data_reg;
    logic [SIGNAL_COUNT-1:0] valid_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en && !wr.clear)
        begin
            mem[wr_idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.wr_en)
            begin
                valid_reg[wr_idx] <= !wr.clear;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    // unwritten or cleared entries read as default action, all zero
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/core/signal_mask_nesting_stack.sv =====
// Top level of the signal mask nesting stack: command port, config port,
// frame stack memory and sequencing. Depends on smns_pkg, smns_action_table.
//
// Channel   Direction  Handshake                 Transfer
// command   in         start / busy              start high while busy low
// result    out        done strobe               every cycle done is high
// config    in         cfg_valid / cfg_ready     cfg_valid and cfg_ready high
//
// Set action, deliver and push: the accept edge reads the action table into its
// read register and enters S_EXEC; the edge out of S_EXEC updates state and result.
// Poll goes on from S_EXEC to S_POLL, with one frame-stack read per popped frame.
// done is high for one cycle; busy drops in that same cycle so a new command
// can be taken. The receiver cannot stall. Reset clears control state at once;
// the action table comes up as default through valid flops, so no sweep.
module signal_mask_nesting_stack
    import smns_pkg::*;
#(
    parameter int FRAME_DEPTH  = 8,
    parameter int SIGNAL_COUNT = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           opcode,
    input  logic [SIG_W-1:0]     signal_number,
    input  logic                 is_async,
    input  logic                 query_only,
    input  logic [HANDLER_W-1:0] new_action_handler,
    input  logic [WORD_W-1:0]    new_action_mask,
    input  logic [WORD_W-1:0]    new_action_flags,
    input  logic [WORD_W-1:0]    stack_pointer,
    input  logic [WORD_W-1:0]    program_counter,
    // result
    output logic                 done,
    output logic [1:0]           status,
    output logic [1:0]           old_action,
    output logic [HANDLER_W-1:0] old_handler,
    output logic [WORD_W-1:0]    old_mask,
    output logic [WORD_W-1:0]    entry_flags,
    output logic [WORD_W-1:0]    blocked_mask,
    output logic [3:0]           frame_depth,
    output logic [3:0]           frames_popped,
    output logic                 restore_registers,
    output logic [2:0]           restore_slot,
    output logic                 recheck_pending,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam int IW  = $clog2(SIGNAL_COUNT);
    localparam int FAW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int DW  = $clog2(FRAME_DEPTH + 1);
    localparam logic [DW-1:0]  DEPTH_MAX = DW'(FRAME_DEPTH);
    localparam logic [SIG_W:0] SIG_LIMIT = (SIG_W + 1)'(SIGNAL_COUNT);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_POLL = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [WORD_W-1:0] nodefer_reg, resethand_reg;
    logic [SIG_W-1:0]  kill_reg, stop_reg;

    // latched command
    opcode_t              opcode_reg;
    logic [SIG_W-1:0]     sig_reg;
    logic                 async_reg, query_reg;
    logic [HANDLER_W-1:0] handler_reg;
    logic [WORD_W-1:0]    nmask_reg, nflags_reg, sp_reg, pc_reg;

    // architectural state
    logic [WORD_W-1:0] blocked_reg, blocked_next;
    logic [DW-1:0]     depth_reg, depth_next;

    // result registers
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [1:0]           kind_reg, kind_next;
    logic [HANDLER_W-1:0] ohandler_reg, ohandler_next;
    logic [WORD_W-1:0]    omask_reg, omask_next;
    logic [WORD_W-1:0]    oflags_reg, oflags_next;
    logic [DW-1:0]        popped_reg, popped_next;
    logic                 restore_reg, restore_next;
    logic [2:0]           slot_reg, slot_next;
    logic                 recheck_reg, recheck_next;

    // frame stack memory
    frame_t           frame_mem [FRAME_DEPTH];
    frame_t           frame_rd_reg;
    frame_t           frame_wr;
    logic             frame_we;
    logic [FAW-1:0]   frame_rd_addr;
    logic [DW-1:0]    depth_less;

    // action table
    logic          accept;
    action_entry_t entry;
    table_wr_t     tbl_wr;

    logic             sig_ok, sig_protected, has_room, pop;
    logic [WORD_W-1:0] add_mask;
    logic [3:0]       slot_wide;

    function automatic logic signal_number_ok(input logic [SIG_W-1:0] s);
        signal_number_ok = (s != '0) && ({1'b0, s} < SIG_LIMIT);
    endfunction

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    smns_action_table #(
        .SIGNAL_COUNT (SIGNAL_COUNT)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_idx   (signal_number[IW-1:0]),
        .rd_entry (entry),
        .wr       (tbl_wr),
        .wr_idx   (sig_reg[IW-1:0])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodefer_reg   <= 32'h4000_0000;
            resethand_reg <= 32'h8000_0000;
            kill_reg      <= 5'd9;
            stop_reg      <= 5'd19;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NODEFER:   nodefer_reg   <= cfg_data;
                CFG_RESETHAND: resethand_reg <= cfg_data;
                CFG_KILL:      kill_reg      <= cfg_data[SIG_W-1:0];
                CFG_STOP:      stop_reg      <= cfg_data[SIG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg  <= opcode_t'(opcode);
            sig_reg     <= signal_number;
            async_reg   <= is_async;
            query_reg   <= query_only;
            handler_reg <= new_action_handler;
            nmask_reg   <= new_action_mask;
            nflags_reg  <= new_action_flags;
            sp_reg      <= stack_pointer;
            pc_reg      <= program_counter;
        end
    end

    // frame stack: written at the top on push, top entry re-read whenever the
    // post-update depth is nonzero, so after a pop the next frame is ready in the following cycle
    assign depth_less    = depth_next - 1'b1;
    assign frame_rd_addr = depth_less[FAW-1:0];

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[depth_reg[FAW-1:0]] <= frame_wr;
        end
        if (depth_next != '0)
        begin
            frame_rd_reg <= frame_mem[frame_rd_addr];
        end
    end

    assign sig_ok        = (signal_number_ok(sig_reg));
    assign sig_protected = (sig_reg == kill_reg) || (sig_reg == stop_reg);
    assign has_room      = (depth_reg < DEPTH_MAX);
    assign pop           = (depth_reg != '0) && (sp_reg > frame_rd_reg.entry_sp);
    // index of the frame being popped, the top one
    assign slot_wide     = 4'(depth_reg - 1'b1);

    always_comb
    begin
        state_next    = state_reg;
        blocked_next  = blocked_reg;
        depth_next    = depth_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        kind_next     = kind_reg;
        ohandler_next = ohandler_reg;
        omask_next    = omask_reg;
        oflags_next   = oflags_reg;
        popped_next   = popped_reg;
        restore_next  = restore_reg;
        slot_next     = slot_reg;
        recheck_next  = recheck_reg;
        frame_we      = 1'b0;
        frame_wr      = '{signal: sig_reg, saved_mask: blocked_reg, entry_sp: sp_reg,
                          return_pc: pc_reg, has_save: async_reg};
        tbl_wr        = '{wr_en: 1'b0, clear: 1'b0, data: '0};
        add_mask      = entry.mask;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next    = S_IDLE;
                done_next     = 1'b1;
                status_next   = STATUS_OK;
                kind_next     = KIND_DEFAULT;
                ohandler_next = '0;
                omask_next    = '0;
                oflags_next   = '0;
                popped_next   = '0;
                restore_next  = 1'b0;
                slot_next     = '0;
                recheck_next  = 1'b0;

                // old entry report shared by set action and deliver
                if (opcode_reg == OP_SET_ACTION || opcode_reg == OP_DELIVER)
                begin
                    if (entry.kind == KIND_IGNORE)
                    begin
                        kind_next = KIND_IGNORE;
                    end
                    else if (entry.kind == KIND_HANDLER)
                    begin
                        kind_next     = KIND_HANDLER;
                        ohandler_next = entry.handler;
                    end
                    omask_next  = entry.mask;
                    oflags_next = entry.flags;
                end

                unique case (opcode_reg)
                    OP_SET_ACTION:
                    begin
                        if (!sig_ok || sig_protected)
                        begin
                            status_next   = STATUS_INVALID;
                            kind_next     = KIND_DEFAULT;
                            ohandler_next = '0;
                            omask_next    = '0;
                            oflags_next   = '0;
                        end
                        else if (!query_reg)
                        begin
                            tbl_wr.wr_en = 1'b1;
                            if (handler_reg == 48'd0)
                            begin
                                tbl_wr.data.kind = KIND_DEFAULT;
                            end
                            else if (handler_reg == 48'd1)
                            begin
                                tbl_wr.data.kind = KIND_IGNORE;
                            end
                            else
                            begin
                                tbl_wr.data.kind    = KIND_HANDLER;
                                tbl_wr.data.handler = handler_reg;
                            end
                            tbl_wr.data.mask  = nmask_reg;
                            tbl_wr.data.flags = nflags_reg;
                        end
                    end

                    OP_DELIVER:
                    begin
                        if (!sig_ok)
                        begin
                            status_next   = STATUS_INVALID;
                            kind_next     = KIND_DEFAULT;
                            ohandler_next = '0;
                            omask_next    = '0;
                            oflags_next   = '0;
                        end
                        else
                        begin
                            if ((entry.flags & nodefer_reg) == '0)
                            begin
                                add_mask = entry.mask | (32'd1 << (sig_reg - 5'd1));
                            end
                            if (has_room)
                            begin
                                frame_we   = 1'b1;
                                depth_next = depth_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                            // mask still applies when the stack is full
                            blocked_next = blocked_reg | add_mask;
                            if ((entry.flags & resethand_reg) != '0)
                            begin
                                tbl_wr.wr_en = 1'b1;
                                tbl_wr.clear = 1'b1;
                            end
                        end
                    end

                    OP_PUSH_FRAME:
                    begin
                        frame_wr.signal   = '0;
                        frame_wr.has_save = 1'b1;
                        if (has_room)
                        begin
                            frame_we   = 1'b1;
                            depth_next = depth_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                        end
                    end

                    OP_POLL_RETURN:
                    begin
                        // top frame read lands next cycle
                        done_next  = 1'b0;
                        state_next = S_POLL;
                    end

                    default: ;
                endcase
            end

            S_POLL:
            begin
                if (pop)
                begin
                    depth_next   = depth_reg - 1'b1;
                    blocked_next = frame_rd_reg.saved_mask;
                    popped_next  = popped_reg + 1'b1;
                    // exact return to the interruption point; lowest frame wins
                    if (frame_rd_reg.has_save &&
                        sp_reg == (frame_rd_reg.entry_sp + 32'd1) &&
                        pc_reg == frame_rd_reg.return_pc)
                    begin
                        restore_next = 1'b1;
                        slot_next    = slot_wide[2:0];
                    end
                end
                else
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    recheck_next = (popped_reg != '0);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            blocked_reg <= '0;
            depth_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            blocked_reg <= blocked_next;
            depth_reg   <= depth_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        kind_reg     <= kind_next;
        ohandler_reg <= ohandler_next;
        omask_reg    <= omask_next;
        oflags_reg   <= oflags_next;
        popped_reg   <= popped_next;
        restore_reg  <= restore_next;
        slot_reg     <= slot_next;
        recheck_reg  <= recheck_next;
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign old_action        = kind_reg;
    assign old_handler       = ohandler_reg;
    assign old_mask          = omask_reg;
    assign entry_flags       = oflags_reg;
    assign blocked_mask      = blocked_reg;
    assign frame_depth       = 4'(depth_reg);
    assign frames_popped     = 4'(popped_reg);
    assign restore_registers = restore_reg;
    assign restore_slot      = slot_reg;
    assign recheck_pending   = recheck_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("frame depth above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted command did not start execution");

    a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POLL && pop) |=> (depth_reg == $past(depth_reg) - 1'b1))
        else $error("pop did not drop depth by one");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && opcode_reg == OP_PUSH_FRAME && depth_reg == DEPTH_MAX)
        |=> (status_reg == STATUS_FULL && depth_reg == $past(depth_reg)))
        else $error("push on full stack changed depth or missed status");

endmodule
